// ===== src/ffrpa_pkg.sv =====
// Shared types and codes for the first-fit record page allocator.
// No dependencies; every other file of the block but ffrpa_byte_mem imports this package.
package ffrpa_pkg;

  // Operation codes carried by an input item
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;

  // A page holding this many records takes no more
  localparam logic [6:0] COUNT_LIMIT = 7'd127;

  // Width of (count + 1) * length products
  localparam int PROD_W = 15;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic [6:0] record_len;
    logic [6:0] page_select;
    logic [6:0] byte_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] page_index;
    logic [6:0] record_offset;
    logic [7:0] read_byte;
    logic [6:0] page_records;
    logic [6:0] page_record_len;
  } out_item_t;

  // Per-page metadata word
  typedef struct packed {
    logic [6:0] count;
    logic [6:0] len;
  } meta_t;

endpackage

// ===== src/ffrpa_meta_mem.sv =====
// Page metadata memory: record count and record length per page.
// One write port, one registered read port. Uses ffrpa_pkg.
module ffrpa_meta_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output ffrpa_pkg::meta_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  ffrpa_pkg::meta_t wr_data
);
  import ffrpa_pkg::*;

  meta_t mem [DEPTH];

  // Write, and register the read word; hold it while no read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/ffrpa_byte_mem.sv =====
// Record byte memory, addressed as {page, byte within page}.
// One write port, one registered read port. No package dependency.
module ffrpa_byte_mem #(
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [2**AW];

  // Write, and register the read byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/first_fit_record_page_allocator_core.sv =====
// Top level of the first-fit record page allocator.
// Depends on ffrpa_pkg, ffrpa_meta_mem and ffrpa_byte_mem.
//
// Records arrive one byte per item and are packed into PAGE_COUNT pages of
// PAGE_BYTES bytes; page metadata lives in a synchronous memory with a
// registered read and is searched first-fit, one page per cycle. A middle
// byte of a record is written, if its record has a page, as it is taken;
// a last byte, a read or a zero-length byte passes through a state that
// forms its result; the first byte of a longer record scans the pages from
// page 0 until one has room or every page has failed. A one-byte record,
// whose first byte is also its last, scans and then forms its result. Any
// item that ends in a result also waits while the output register is full.
// After reset the metadata memory is cleared in a pass over every page,
// during which no item is accepted. A result sits in an output
// register, so the next item is taken while a result waits.
module first_fit_record_page_allocator_core #(
  parameter int PAGE_COUNT = 128,
  parameter int PAGE_BYTES = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffrpa_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ffrpa_pkg::out_item_t out_item
);
  import ffrpa_pkg::*;

  localparam int PAGE_AW = $clog2(PAGE_COUNT);
  localparam int BOFF_AW = $clog2(PAGE_BYTES);
  localparam int BYTE_AW = PAGE_AW + BOFF_AW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // Control state
  logic [2:0]         state;
  logic [PAGE_AW-1:0] clr_idx;
  logic [PAGE_AW-1:0] scan_idx;
  logic [6:0]         pos;
  logic [6:0]         latched_len;
  logic               cur_ok;
  logic [PAGE_AW-1:0] target;
  // Payload registers
  logic [BOFF_AW-1:0] base;
  logic [6:0]         rec_count;
  logic [7:0]         first_byte;
  logic [6:0]         rd_psel;
  logic               rd_page_ok;
  logic               rd_off_ok;
  out_item_t          res;

  // Memory ports
  logic               meta_rd_en;
  logic [PAGE_AW-1:0] meta_rd_addr;
  meta_t              meta_rd_data;
  logic               meta_wr_en;
  logic [PAGE_AW-1:0] meta_wr_addr;
  meta_t              meta_wr_data;
  logic               byte_rd_en;
  logic [BYTE_AW-1:0] byte_rd_addr;
  logic [7:0]         byte_rd_data;
  logic               byte_wr_en;
  logic [BYTE_AW-1:0] byte_wr_addr;
  logic [7:0]         byte_wr_data;

  // Decoded input
  logic               accept;
  logic               is_read;
  logic               first;
  logic [PAGE_AW+6:0] psel_ext;
  logic [BOFF_AW+6:0] boff_ext;
  logic [PAGE_AW-1:0] psel_trim;
  logic [BOFF_AW-1:0] boff_trim;
  logic               page_in_range;
  logic               off_in_range;

  // Scan evaluation
  logic [7:0]         cnt_inc;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  base_calc;
  logic [BOFF_AW-1:0] base_new;
  logic               fit;
  logic               scan_last;
  logic               clr_last;

  // Byte placement and result fields
  logic [BOFF_AW+7:0] mid_off_sum;
  logic               last_mid;
  logic [PAGE_AW+6:0] tgt_ext;
  logic [PAGE_AW+6:0] scan_ext;
  logic [BOFF_AW+6:0] base_ext;
  logic [BOFF_AW+6:0] base_new_ext;
  logic               out_free;
  out_item_t          res_no_room;
  out_item_t          res_stored;
  out_item_t          res_scan;
  out_item_t          res_read;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_read  = (in_item.opcode == OP_READ);
  assign first    = (pos == 7'd0);
  assign out_free = !out_valid || out_ready;

  // Fit the 7-bit select and offset fields onto the memory address widths
  assign psel_ext      = {{PAGE_AW{1'b0}}, in_item.page_select};
  assign boff_ext      = {{BOFF_AW{1'b0}}, in_item.byte_offset};
  assign psel_trim     = psel_ext[PAGE_AW-1:0];
  assign boff_trim     = boff_ext[BOFF_AW-1:0];
  assign page_in_range = int'(in_item.page_select) < PAGE_COUNT;
  assign off_in_range  = int'(in_item.byte_offset) < PAGE_BYTES;

  // A page fits when below the count limit, length matches or page empty,
  // and (count + 1) * len < PAGE_BYTES, i.e. len is under the free bytes
  assign cnt_inc   = {1'b0, meta_rd_data.count} + 8'd1;
  assign prod      = PROD_W'(cnt_inc) * PROD_W'(latched_len);
  assign base_calc = prod - PROD_W'(latched_len);
  assign base_new  = base_calc[BOFF_AW-1:0];
  assign fit       = (meta_rd_data.count < COUNT_LIMIT) &&
                     ((meta_rd_data.len == latched_len) || (meta_rd_data.len == 7'd0)) &&
                     (prod < PROD_W'(PAGE_BYTES));
  assign scan_last = (scan_idx == PAGE_AW'(PAGE_COUNT - 1));
  assign clr_last  = (clr_idx == PAGE_AW'(PAGE_COUNT - 1));

  // Byte slot of a later byte, and the last-byte test
  assign mid_off_sum = {8'b0, base} + {{(BOFF_AW + 1){1'b0}}, pos};
  assign last_mid    = ({1'b0, pos} + 8'd1) >= {1'b0, latched_len};

  assign tgt_ext      = {7'b0, target};
  assign scan_ext     = {7'b0, scan_idx};
  assign base_ext     = {7'b0, base};
  assign base_new_ext = {7'b0, base_new};

  // Candidate result items
  always_comb begin
    res_no_room = '{status: ST_NO_ROOM, page_index: 7'd0, record_offset: 7'd0,
                    read_byte: 8'd0, page_records: 7'd0, page_record_len: 7'd0};
    res_stored  = '{status: ST_STORED, page_index: tgt_ext[6:0],
                    record_offset: base_ext[6:0], read_byte: 8'd0,
                    page_records: rec_count, page_record_len: latched_len};
    res_scan    = '{status: ST_STORED, page_index: scan_ext[6:0],
                    record_offset: base_new_ext[6:0], read_byte: 8'd0,
                    page_records: cnt_inc[6:0], page_record_len: latched_len};
    res_read    = '{status: ST_READ, page_index: rd_psel, record_offset: 7'd0,
                    read_byte: (rd_page_ok && rd_off_ok) ? byte_rd_data : 8'd0,
                    page_records: rd_page_ok ? meta_rd_data.count : 7'd0,
                    page_record_len: rd_page_ok ? meta_rd_data.len : 7'd0};
  end

  // Drive memory ports from the current state and the accepted item
  always_comb begin
    meta_rd_en   = 1'b0;
    meta_rd_addr = '0;
    meta_wr_en   = 1'b0;
    meta_wr_addr = clr_idx;
    meta_wr_data = '0;
    byte_rd_en   = 1'b0;
    byte_rd_addr = {psel_trim, boff_trim};
    byte_wr_en   = 1'b0;
    byte_wr_addr = {target, mid_off_sum[BOFF_AW-1:0]};
    byte_wr_data = in_item.data_byte;
    case (state)
      S_CLEAR: begin
        meta_wr_en = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          if (is_read) begin
            meta_rd_en   = 1'b1;
            meta_rd_addr = psel_trim;
            byte_rd_en   = 1'b1;
          end else if (first) begin
            meta_rd_en = (in_item.record_len != 7'd0);
          end else begin
            byte_wr_en = cur_ok;
          end
        end
      end
      S_SCAN: begin
        if (fit) begin
          meta_wr_en   = 1'b1;
          meta_wr_addr = scan_idx;
          meta_wr_data = '{count: cnt_inc[6:0], len: latched_len};
          byte_wr_en   = 1'b1;
          byte_wr_addr = {scan_idx, base_new};
          byte_wr_data = first_byte;
        end else if (!scan_last) begin
          meta_rd_en   = 1'b1;
          meta_rd_addr = scan_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      scan_idx    <= '0;
      pos         <= 7'd0;
      latched_len <= 7'd0;
      cur_ok      <= 1'b0;
      target      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (is_read) begin
              rd_psel    <= in_item.page_select;
              rd_page_ok <= page_in_range;
              rd_off_ok  <= off_in_range;
              state      <= S_READ;
            end else if (first) begin
              latched_len <= in_item.record_len;
              first_byte  <= in_item.data_byte;
              cur_ok      <= 1'b0;
              target      <= '0;
              if (in_item.record_len == 7'd0) begin
                res   <= res_no_room;
                state <= S_EMIT;
              end else begin
                scan_idx <= '0;
                state    <= S_SCAN;
              end
            end else if (last_mid) begin
              pos   <= 7'd0;
              res   <= cur_ok ? res_stored : res_no_room;
              state <= S_EMIT;
            end else begin
              pos <= pos + 7'd1;
            end
          end
        end
        S_SCAN: begin
          if (fit) begin
            cur_ok    <= 1'b1;
            target    <= scan_idx;
            base      <= base_new;
            rec_count <= cnt_inc[6:0];
            if (latched_len == 7'd1) begin
              res   <= res_scan;
              state <= S_EMIT;
            end else begin
              pos   <= 7'd1;
              state <= S_IDLE;
            end
          end else if (scan_last) begin
            // No page has room: drop the record's bytes
            if (latched_len == 7'd1) begin
              res   <= res_no_room;
              state <= S_EMIT;
            end else begin
              pos   <= 7'd1;
              state <= S_IDLE;
            end
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_READ: begin
          if (out_free) begin
            out_item  <= res_read;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_item  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ffrpa_meta_mem #(
    .DEPTH (PAGE_COUNT),
    .AW    (PAGE_AW)
  ) u_meta_mem (
    .clk     (clk),
    .rd_en   (meta_rd_en),
    .rd_addr (meta_rd_addr),
    .rd_data (meta_rd_data),
    .wr_en   (meta_wr_en),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr_data)
  );

  ffrpa_byte_mem #(
    .AW (BYTE_AW)
  ) u_byte_mem (
    .clk     (clk),
    .rd_en   (byte_rd_en),
    .rd_addr (byte_rd_addr),
    .rd_data (byte_rd_data),
    .wr_en   (byte_wr_en),
    .wr_addr (byte_wr_addr),
    .wr_data (byte_wr_data)
  );

endmodule

// ===== src/ffrpa_checker.sv =====
// Port-level checks for the first-fit record page allocator.
// Depends on ffrpa_pkg; bound to first_fit_record_page_allocator_core below.
module ffrpa_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input ffrpa_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input logic                 out_ready,
  input ffrpa_pkg::out_item_t out_item
);
  import ffrpa_pkg::*;

  // Hold a stalled result item unchanged
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed or vanished while stalled");

  // Stop taking items while a read answer is formed
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_item.opcode == OP_READ) |=> !in_ready)
    else $error("item accepted right after a read");

  // A dropped record reports no page and no metadata
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == ST_NO_ROOM) |->
      (out_item.page_index == 7'd0) && (out_item.record_offset == 7'd0) &&
      (out_item.read_byte == 8'd0) && (out_item.page_records == 7'd0) &&
      (out_item.page_record_len == 7'd0))
    else $error("no-room item carries nonzero fields");

  // A stored record leaves its page with at least one record of nonzero length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == ST_STORED) |->
      (out_item.page_records != 7'd0) && (out_item.page_record_len != 7'd0) &&
      (out_item.read_byte == 8'd0))
    else $error("stored item with empty page metadata");

  // A read answer carries no record offset
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == ST_READ) |-> (out_item.record_offset == 7'd0))
    else $error("read answer with nonzero record offset");

endmodule

bind first_fit_record_page_allocator_core ffrpa_checker u_checker (.*);

// ===== tb/sv/first_fit_record_page_allocator_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for first_fit_record_page_allocator_core: drives record bytes and reads,
// predicts page choice, offsets and read data, and checks every result in order.
// Depends on ffrpa_pkg and the core RTL only.
module first_fit_record_page_allocator_core_tb;
  import ffrpa_pkg::*;

  localparam int PAGE_N = 128;
  localparam int PAGE_SZ = 128;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  // Allocator image kept by the testbench
  logic [6:0] pg_count [PAGE_N] = '{default: '0};
  logic [6:0] pg_len [PAGE_N] = '{default: '0};
  logic [7:0] pg_data [PAGE_N * PAGE_SZ];
  bit pg_written [PAGE_N * PAGE_SZ] = '{default: 1'b0};
  int written_addrs[$];
  int rec_pos = 0;
  int rec_page = 0;
  bit rec_ok = 1'b0;
  int rec_len = 0;

  out_item_t expected_results[$];
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [7:0] ready_tick = '0;
  logic [31:0] ready_mask = '0;

  first_fit_record_page_allocator_core #(
    .PAGE_COUNT(PAGE_N),
    .PAGE_BYTES(PAGE_SZ)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A page takes a record if it is below the record limit, is empty or holds
  // that length, and the record still fits strictly inside the free bytes
  function automatic bit page_takes(int pg, int len);
    int cnt;
    int avail;
    cnt = pg_count[pg];
    if (cnt >= COUNT_LIMIT) return 1'b0;
    avail = (cnt == 0) ? PAGE_SZ : PAGE_SZ - cnt * len;
    return (pg_len[pg] == len || pg_len[pg] == 0) && len < avail;
  endfunction

  function automatic int first_fit_page(int len);
    for (int pg = 0; pg < PAGE_N; pg++) begin
      if (page_takes(pg, len)) return pg;
    end
    return -1;
  endfunction

  // Advance the allocator image by one accepted item and queue its result
  task automatic alloc_predict(input in_item_t it);
    out_item_t res;
    int pg;
    int addr;
    int idx;
    res = '0;
    if (it.opcode == OP_READ) begin
      res.status = ST_READ;
      res.page_index = it.page_select;
      if (it.page_select < PAGE_N) begin
        res.page_records = pg_count[it.page_select];
        res.page_record_len = pg_len[it.page_select];
        if (it.byte_offset < PAGE_SZ)
          res.read_byte = pg_data[it.page_select * PAGE_SZ + it.byte_offset];
      end
      expected_results.push_back(res);
      return;
    end
    // First byte: latch the length and claim a page
    if (rec_pos == 0) begin
      rec_len = it.record_len;
      rec_ok = 1'b0;
      rec_page = 0;
      if (rec_len != 0) begin
        pg = first_fit_page(rec_len);
        if (pg >= 0) begin
          rec_ok = 1'b1;
          rec_page = pg;
          pg_count[pg] = pg_count[pg] + 7'd1;
          pg_len[pg] = 7'(rec_len);
        end
      end
    end
    if (rec_ok) begin
      addr = (pg_count[rec_page] - 1) * rec_len + rec_pos;
      if (addr < PAGE_SZ) begin
        idx = rec_page * PAGE_SZ + addr;
        pg_data[idx] = it.data_byte;
        if (!pg_written[idx]) begin
          pg_written[idx] = 1'b1;
          written_addrs.push_back(idx);
        end
      end
    end
    // Last byte: report placement or drop
    if (rec_pos + 1 >= rec_len) begin
      rec_pos = 0;
      if (rec_ok) begin
        res.status = ST_STORED;
        res.page_index = 7'(rec_page);
        res.record_offset = 7'((pg_count[rec_page] - 1) * rec_len);
        res.page_records = pg_count[rec_page];
        res.page_record_len = pg_len[rec_page];
      end else begin
        res.status = ST_NO_ROOM;
      end
      expected_results.push_back(res);
    end else begin
      rec_pos++;
    end
  endtask

  // Send one item: bursts of random length, random gaps between bursts
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    alloc_predict(it);
  endtask

  task automatic send_read(input int page, input int offset);
    in_item_t it;
    logic [31:0] noise;
    noise = $urandom;
    it = noise[$bits(in_item_t)-1:0];
    it.opcode = OP_READ;
    it.page_select = 7'(page);
    it.byte_offset = 7'(offset);
    send_item(it);
  endtask

  // Read back a byte that is known to have been written
  task automatic read_stored_byte();
    int idx;
    if (written_addrs.size() == 0) return;
    idx = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    send_read(idx / PAGE_SZ, idx % PAGE_SZ);
  endtask

  // Send a whole record; the length field on later bytes is noise and
  // reads may fall between the bytes
  task automatic send_record(input int len, input int read_pct);
    in_item_t it;
    logic [31:0] noise;
    int nbytes;
    nbytes = (len == 0) ? 1 : len;
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(1, 100) <= read_pct) read_stored_byte();
      noise = $urandom;
      it = noise[$bits(in_item_t)-1:0];
      it.opcode = OP_STORE;
      if (i == 0) it.record_len = 7'(len);
      send_item(it);
    end
  endtask

  task automatic test_directed();
    in_item_t it;
    it = '0;
    // one-byte records at both data extremes, then read them back
    it.opcode = OP_STORE;
    it.record_len = 7'd1;
    it.data_byte = 8'h00;
    send_item(it);
    it.data_byte = 8'hFF;
    it.page_select = 7'h7F;
    it.byte_offset = 7'h7F;
    send_item(it);
    send_read(0, 0);
    send_read(0, 1);
    // zero length: taken as one byte and always dropped
    it.record_len = 7'd0;
    it.data_byte = 8'h5A;
    send_item(it);
    // three-byte record with reads between bytes and a changing length field
    it.record_len = 7'd3;
    it.data_byte = 8'hA5;
    send_item(it);
    send_read(1, 0);
    it.record_len = 7'd127;
    it.data_byte = 8'h3C;
    send_item(it);
    send_read(0, 1);
    it.record_len = 7'd0;
    it.data_byte = 8'hC3;
    send_item(it);
    send_read(1, 2);
    send_record(2, 0);
    send_read(2, 1);
  endtask

  // Fill the one-byte page up to its record limit with COUNT_LIMIT + 1 one-byte records, and spill the rest past it
  task automatic test_count_limit();
    int pg;
    pg = first_fit_page(1);
    for (int i = 0; i < COUNT_LIMIT + 1; i++) send_record(1, 10);
    send_read(pg, COUNT_LIMIT - 1);
  endtask

  task automatic test_random();
    int stop_at;
    int pick;
    int len;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      pick = $urandom_range(1, 100);
      if (pick <= 20) begin
        read_stored_byte();
      end else if (pick <= 25) begin
        send_record(0, 10);
      end else begin
        // mostly short records, a few up to the largest length
        pick = $urandom_range(1, 100);
        if (pick <= 85) len = $urandom_range(1, 8);
        else if (pick <= 95) len = $urandom_range(9, 40);
        else len = $urandom_range(64, 127);
        send_record(len, 10);
      end
    end
  endtask

  // Push records onto fresh pages, cheapest length first, until the search
  // lands past the first quarter of the pool
  task automatic test_deep_pages();
    int landed;
    int len_pick;
    int pg;
    landed = 0;
    len_pick = 1;
    while (landed < PAGE_N / 4 && len_pick != 0) begin
      len_pick = 0;
      for (int l = 1; l < PAGE_SZ && len_pick == 0; l++) begin
        pg = first_fit_page(l);
        if (pg >= 0 && pg_count[pg] == 0) len_pick = l;
      end
      if (len_pick != 0) begin
        landed = first_fit_page(len_pick);
        send_record(len_pick, 5);
      end
    end
    for (int i = 0; i < len_pick; i++) send_read(landed, i);
    repeat (40) read_stored_byte();
  endtask

  function automatic string show(out_item_t r);
    return $sformatf("st=%0d pg=%0d off=%0d byte=%02h recs=%0d len=%0d", r.status,
                     r.page_index, r.record_offset, r.read_byte, r.page_records,
                     r.page_record_len);
  endfunction

  // Receiver: open windows alternate with windows that follow a random mask
  always @(posedge clk) begin
    ready_tick <= ready_tick + 8'd1;
    if (ready_tick[4:0] == 5'd0)
      ready_mask <= ready_tick[5] ? ($urandom | $urandom) : ($urandom & $urandom);
    out_ready <= ready_tick[7] | ready_mask[ready_tick[4:0]];
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: %s", show(out_item));
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status || out_item.page_index !== want.page_index ||
            out_item.record_offset !== want.record_offset ||
            out_item.read_byte !== want.read_byte ||
            out_item.page_records !== want.page_records ||
            out_item.page_record_len !== want.page_record_len) begin
          if (mismatches < 10)
            $display("mismatch: exp %s / got %s", show(want), show(out_item));
          mismatches++;
        end
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_count_limit();
    test_random();
    test_deep_pages();
    // drain outstanding results, then let the block settle
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * PAGE_N + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
